// ===== design/olst_pkg.sv =====
// Package for the ordered list store: word types, codes and the command and
// status structs that join the controller to the datapath.
// No dependencies.
`default_nettype none

package olst_pkg;

  localparam int DATA_W  = 32;
  localparam int FIELD_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   position;
    logic [FIELD_W-1:0]   entry_count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_SHIFT  = 3'd3,
    S_RESULT = 3'd4
  } state_t;

  typedef enum logic [1:0] {
    RD_FIRST = 2'd0,
    RD_IDX1  = 2'd1,
    RD_IDX2  = 2'd2
  } rd_src_t;

  typedef enum logic {
    WR_TAIL  = 1'b0,
    WR_SHIFT = 1'b1
  } wr_src_t;

  typedef struct packed {
    logic    take_in;
    logic    ram_rd;
    rd_src_t rd_src;
    logic    ram_wr;
    wr_src_t wr_src;
    logic    idx_clr;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_status;
    logic    res_found;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic full;
    logic empty;
    logic match;
    logic scan_last;
    logic shift_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/olst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/olst_ctrl.sv =====
// Controller state machine of the ordered list store: sequences decode,
// scan, shift and result hand-off. Depends on olst_pkg.
`default_nettype none

module olst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire olst_pkg::dp_sts_t sts,
  output olst_pkg::dp_cmd_t      cmd
);

  import olst_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_src     = RD_FIRST;
    cmd.wr_src     = WR_TAIL;
    cmd.res_status = ST_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.command)
          CMD_INSERT: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_RESULT;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.ram_wr  = 1'b1;
              cmd.wr_src  = WR_TAIL;
              cmd.cnt_inc = 1'b1;
            end
          end
          CMD_DELETE, CMD_SEARCH: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_RESULT;
            end else begin
              cmd.ram_rd  = 1'b1;
              cmd.rd_src  = RD_FIRST;
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_NOT_FOUND;
            state_nxt      = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_found  = 1'b1;
          if (sts.command == CMD_SEARCH) begin
            state_nxt = S_RESULT;
          end else if (sts.scan_last) begin
            cmd.cnt_dec = 1'b1;
            state_nxt   = S_RESULT;
          end else begin
            cmd.ram_rd = 1'b1;
            cmd.rd_src = RD_IDX1;
            state_nxt  = S_SHIFT;
          end
        end else if (sts.scan_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_RESULT;
        end else begin
          cmd.ram_rd  = 1'b1;
          cmd.rd_src  = RD_IDX1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.ram_wr = 1'b1;
        cmd.wr_src = WR_SHIFT;
        if (sts.shift_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESULT;
        end else begin
          cmd.ram_rd  = 1'b1;
          cmd.rd_src  = RD_IDX2;
          cmd.idx_inc = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/olst_dp.sv =====
// Datapath of the ordered list store: entry memory, count, scan index,
// result and output registers. Depends on olst_pkg and olst_ram.
`default_nettype none

module olst_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire olst_pkg::in_word_t in_data,
  output olst_pkg::out_word_t     out_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire olst_pkg::dp_cmd_t  cmd,
  output olst_pkg::dp_sts_t       sts
);

  import olst_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = CW + 1;

  cmd_t               cmd_r;
  logic [DATA_W-1:0]  val_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      idx_nxt;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  status_t            res_status_r;
  logic [FIELD_W-1:0] res_pos_r;
  out_word_t          out_r;
  logic               out_valid_r;
  logic               out_valid_nxt;

  logic [SW-1:0]      idx_ext;
  logic [SW-1:0]      idx_p1;
  logic [SW-1:0]      idx_p2;
  logic [SW-1:0]      cnt_ext;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [DATA_W-1:0]  rd_data;

  assign idx_ext = SW'(idx_r);
  assign idx_p1  = idx_ext + SW'(1);
  assign idx_p2  = idx_ext + SW'(2);
  assign cnt_ext = SW'(cnt_r);

  always_comb begin
    unique case (cmd.rd_src)
      RD_FIRST: rd_addr = '0;
      RD_IDX1:  rd_addr = IW'(idx_p1);
      RD_IDX2:  rd_addr = IW'(idx_p2);
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_src)
      WR_TAIL: begin
        wr_addr = IW'(cnt_r);
        wr_data = val_r;
      end
      WR_SHIFT: begin
        wr_addr = idx_r;
        wr_data = rd_data;
      end
      default: begin
        wr_addr = IW'(cnt_r);
        wr_data = val_r;
      end
    endcase
  end

  olst_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.ram_wr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.ram_rd),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IW'(idx_p1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = CW'(cnt_ext + SW'(1));
    end else if (cmd.cnt_dec) begin
      cnt_nxt = CW'(cnt_ext - SW'(1));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cmd_r <= in_data.command;
      val_r <= in_data.item_value;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_pos_r    <= cmd.res_found ? FIELD_W'(idx_p1) : '0;
    end
    if (cmd.out_load) begin
      out_r.status      <= res_status_r;
      out_r.position    <= res_pos_r;
      out_r.entry_count <= FIELD_W'(cnt_r);
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  assign sts.command    = cmd_r;
  assign sts.full       = (cnt_ext == SW'(MAX_ENTRIES));
  assign sts.empty      = (cnt_r == '0);
  assign sts.match      = (rd_data == val_r);
  assign sts.scan_last  = (idx_p1 == cnt_ext);
  assign sts.shift_last = (idx_p2 == cnt_ext);
  assign sts.out_free   = !out_valid_r || out_ready;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= SW'(MAX_ENTRIES))
    else $error("Entry count is above the list capacity.");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("Count grows while the list is full.");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ram_wr && cmd.wr_src == WR_SHIFT) |-> (idx_p1 < cnt_ext))
    else $error("Shift write goes beyond the last stored entry.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_r == $past(out_r)))
    else $error("Pending result word was overwritten.");

endmodule

`default_nettype wire

// ===== design/ordered_list_store.sv =====
// Ordered list store: bounded list of signed 32-bit values in insertion order.
// Top level joining olst_ctrl and olst_dp. Depends on olst_pkg.
//
// Usage: each input word carries a command (insert at tail, delete first
// match, search first match) and a value; exactly one result word comes back
// with a status, the 1-based match position and the entry count afterward.
// Both channels use valid and ready; a word moves when both are high.
// The scan reads one entry per cycle and the gap is closed one entry per
// cycle through the single read and single write port of the entry memory.
// One word is in work at a time; the next input is taken in the cycle after
// the result is placed in the output register. Reset clears the count and
// the output valid flag; entry contents need no clearing. When the receiver
// stalls, the result stays in the output register and the block holds in
// its result state until it can hand over.
`default_nettype none

module ordered_list_store #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire olst_pkg::in_word_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output olst_pkg::out_word_t       out_data
);

  import olst_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  olst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (dp_sts),
    .cmd     (dp_cmd)
  );

  olst_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

endmodule

`default_nettype wire
